>>> rtl/afsp_pkg.sv
// Shared types, codes and header helpers for the ADTS frame sync parser.
`default_nettype none

package afsp_pkg;

   localparam int HDR_BYTES = 7;
   localparam logic [12:0] HDR_LEN = 13'd7;

   // Header bytes one through five; byte zero is always the sync byte, byte six is unused.
   typedef logic [5:1][7:0] afsp_hdr_type;

   typedef struct packed {
      logic         status;
      afsp_hdr_type hdr;
   } afsp_event_type;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_CORRUPT = 1'b1;

   function automatic logic [12:0] hdr_length(input afsp_hdr_type h);
      hdr_length = {h[3][1:0], h[4], h[5][7:5]};
   endfunction

   function automatic logic hdr_valid(input afsp_hdr_type h);
      hdr_valid = (h[2][5:2] < 4'hD) && !(h[1][3] && (h[2][7:6] == 2'd3));
   endfunction

   function automatic logic [16:0] rate_lookup(input logic [3:0] idx);
      case (idx)
         4'd0:    rate_lookup = 17'd96000;
         4'd1:    rate_lookup = 17'd88200;
         4'd2:    rate_lookup = 17'd64000;
         4'd3:    rate_lookup = 17'd48000;
         4'd4:    rate_lookup = 17'd44100;
         4'd5:    rate_lookup = 17'd32000;
         4'd6:    rate_lookup = 17'd24000;
         4'd7:    rate_lookup = 17'd22050;
         4'd8:    rate_lookup = 17'd16000;
         4'd9:    rate_lookup = 17'd12000;
         4'd10:   rate_lookup = 17'd11025;
         4'd11:   rate_lookup = 17'd8000;
         4'd12:   rate_lookup = 17'd7350;
         default: rate_lookup = 17'd0;
      endcase
   endfunction

endpackage

`default_nettype wire

>>> rtl/afsp_front.sv
// Byte-level sync hunt, header capture and frame counting; emits one event per result.
`default_nettype none

module afsp_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [7:0]              req_stream_byte,
   input  wire logic                    req_end_of_stream,
   input  wire logic                    q_full,
   output logic                         evt_push,
   output afsp_pkg::afsp_event_type     evt_data
);
   import afsp_pkg::*;

   localparam logic [2:0] PH_HUNT0 = 3'd0;
   localparam logic [2:0] PH_HUNT1 = 3'd1;
   localparam logic [2:0] PH_HEAD  = 3'd2;
   localparam logic [2:0] PH_BODY  = 3'd3;
   localparam logic [2:0] PH_PEEK  = 3'd4;
   localparam logic [2:0] PH_BAD   = 3'd5;

   logic [2:0]   phase_ff, phase_in;
   logic [12:0]  pos_ff, pos_in;
   logic         ok_ff, ok_in;
   afsp_hdr_type cur_ff, cur_in;
   afsp_hdr_type nxt_ff, nxt_in;
   logic         req_fire;
   logic         match;
   logic [7:0]   b;

   assign req_ready = !q_full;
   assign req_fire  = req_valid && req_ready;
   assign b         = req_stream_byte;

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      ok_in    = ok_ff;
      cur_in   = cur_ff;
      nxt_in   = nxt_ff;
      evt_push = 1'b0;
      evt_data = '0;
      match    = 1'b1;
      if (req_fire) begin
         if (phase_ff == PH_BAD) begin
            evt_push        = 1'b1;
            evt_data.status = STATUS_CORRUPT;
            phase_in        = PH_HUNT0;
         end
         case (phase_in)
            PH_HUNT1: begin
               if ((b & 8'hF6) == 8'hF0) begin
                  cur_in[1] = b;
                  pos_in    = 13'd2;
                  phase_in  = PH_HEAD;
               end else if (b != 8'hFF) begin
                  phase_in = PH_HUNT0;
               end
            end
            PH_HEAD: begin
               case (pos_ff[2:0])
                  3'd2:    cur_in[2] = b;
                  3'd3:    cur_in[3] = b;
                  3'd4:    cur_in[4] = b;
                  3'd5:    cur_in[5] = b;
                  default: cur_in[1] = cur_ff[1];
               endcase
               pos_in = pos_ff + 13'd1;
               if (pos_ff[2:0] == 3'd6) begin
                  if (!hdr_valid(cur_ff) || (hdr_length(cur_ff) < HDR_LEN)) begin
                     evt_push        = 1'b1;
                     evt_data.status = STATUS_CORRUPT;
                     phase_in        = PH_HUNT0;
                     pos_in          = '0;
                  end else if (hdr_length(cur_ff) > HDR_LEN) begin
                     phase_in = PH_BODY;
                     pos_in   = HDR_LEN;
                  end else begin
                     phase_in = PH_PEEK;
                     pos_in   = '0;
                     ok_in    = 1'b1;
                  end
               end
            end
            PH_BODY: begin
               pos_in = pos_ff + 13'd1;
               if (pos_in >= hdr_length(cur_ff)) begin
                  phase_in = PH_PEEK;
                  pos_in   = '0;
                  ok_in    = 1'b1;
               end
            end
            PH_PEEK: begin
               case (pos_ff[2:0])
                  3'd0: match = (b == 8'hFF);
                  3'd1: begin
                     nxt_in[1] = b;
                     match     = (b == cur_ff[1]);
                  end
                  3'd2: begin
                     nxt_in[2] = b;
                     match     = (b == cur_ff[2]);
                  end
                  3'd3: begin
                     nxt_in[3] = b;
                     match     = (b[7:4] == cur_ff[3][7:4]);
                  end
                  3'd4:    nxt_in[4] = b;
                  3'd5:    nxt_in[5] = b;
                  default: match = 1'b1;
               endcase
               ok_in  = ok_ff && match;
               pos_in = pos_ff + 13'd1;
               if (pos_ff[2:0] == 3'd6) begin
                  evt_push = 1'b1;
                  if (ok_ff && hdr_valid(nxt_ff)) begin
                     evt_data.status = STATUS_OK;
                     evt_data.hdr    = cur_ff;
                     cur_in          = nxt_ff;
                     if (hdr_length(nxt_ff) < HDR_LEN) begin
                        phase_in = PH_BAD;
                        pos_in   = '0;
                     end else if (hdr_length(nxt_ff) > HDR_LEN) begin
                        phase_in = PH_BODY;
                        pos_in   = HDR_LEN;
                     end else begin
                        phase_in = PH_PEEK;
                        pos_in   = '0;
                        ok_in    = 1'b1;
                     end
                  end else begin
                     evt_data.status = STATUS_CORRUPT;
                     phase_in        = PH_HUNT0;
                     pos_in          = '0;
                  end
               end
            end
            default: begin
               if (b == 8'hFF) begin
                  phase_in = PH_HUNT1;
               end else begin
                  phase_in = PH_HUNT0;
               end
            end
         endcase
         if (req_end_of_stream) begin
            if (!evt_push && (phase_in == PH_PEEK)) begin
               evt_push        = 1'b1;
               evt_data.status = STATUS_OK;
               evt_data.hdr    = cur_in;
            end
            phase_in = PH_HUNT0;
            pos_in   = '0;
            ok_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT0;
         pos_ff   <= '0;
         ok_ff    <= 1'b1;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         ok_ff    <= ok_in;
      end
      cur_ff <= cur_in;
      nxt_ff <= nxt_in;
   end

endmodule

`default_nettype wire

>>> rtl/afsp_queue.sv
// Short event queue between the byte front end and the result stage.
`default_nettype none

module afsp_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire afsp_pkg::afsp_event_type push_data,
   output logic                          full,
   input  wire logic                     pop,
   output logic                          not_empty,
   output afsp_pkg::afsp_event_type      pop_data
);
   import afsp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULLC = CNT_W'(DEPTH);

   afsp_event_type     mem [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == FULLC);
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("event pushed into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("event popped from empty queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULLC)
      else $error("queue count out of range");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == CNT_W'($past(count_ff) + 1'b1)))
      else $error("queue count did not advance on push");
`endif

endmodule

`default_nettype wire

>>> rtl/afsp_back.sv
// Result stage: unpacks header fields, looks up the sample rate and holds the result beat.
`default_nettype none

module afsp_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     q_not_empty,
   input  wire afsp_pkg::afsp_event_type q_data,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic                          rsp_status,
   output logic                          rsp_is_mpeg2,
   output logic [1:0]                    rsp_profile,
   output logic [3:0]                    rsp_rate_index,
   output logic [16:0]                   rsp_sample_rate,
   output logic [2:0]                    rsp_channel_config,
   output logic [12:0]                   rsp_payload_length,
   output logic                          rsp_crc_present
);
   import afsp_pkg::*;

   logic        valid_ff;
   logic        status_ff, status_in;
   logic        mpeg2_ff, mpeg2_in;
   logic [1:0]  profile_ff, profile_in;
   logic [3:0]  index_ff, index_in;
   logic [16:0] rate_ff, rate_in;
   logic [2:0]  chan_ff, chan_in;
   logic [12:0] plen_ff, plen_in;
   logic        crc_ff, crc_in;

   assign q_pop = q_not_empty && (!valid_ff || rsp_ready);

   always_comb begin
      status_in  = q_data.status;
      mpeg2_in   = 1'b0;
      profile_in = '0;
      index_in   = '0;
      rate_in    = '0;
      chan_in    = '0;
      plen_in    = '0;
      crc_in     = 1'b0;
      if (q_data.status == STATUS_OK) begin
         mpeg2_in   = q_data.hdr[1][3];
         profile_in = q_data.hdr[2][7:6];
         index_in   = q_data.hdr[2][5:2];
         rate_in    = rate_lookup(q_data.hdr[2][5:2]);
         chan_in    = {q_data.hdr[2][0], q_data.hdr[3][7:6]};
         plen_in    = hdr_length(q_data.hdr) - HDR_LEN;
         crc_in     = ~q_data.hdr[1][0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (q_pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
      if (q_pop) begin
         status_ff  <= status_in;
         mpeg2_ff   <= mpeg2_in;
         profile_ff <= profile_in;
         index_ff   <= index_in;
         rate_ff    <= rate_in;
         chan_ff    <= chan_in;
         plen_ff    <= plen_in;
         crc_ff     <= crc_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_is_mpeg2       = mpeg2_ff;
   assign rsp_profile        = profile_ff;
   assign rsp_rate_index     = index_ff;
   assign rsp_sample_rate    = rate_ff;
   assign rsp_channel_config = chan_ff;
   assign rsp_payload_length = plen_ff;
   assign rsp_crc_present    = crc_ff;

endmodule

`default_nettype wire

>>> rtl/adts_frame_sync_parser.sv
// ADTS frame sync parser top level: byte front end, event queue and result stage.
//
// Usage:
//  req_* carries one stream byte per beat, with req_end_of_stream on the last
//  byte of a stream. rsp_* carries zero or one result per input byte: a frame
//  accepted (rsp_status 0, header fields valid) or a corrupted bitstream
//  (rsp_status 1, all other fields zero).
//  Throughput: one byte per cycle while the queue is not full. The front end
//  classifies each byte in the cycle it is accepted and writes any result into
//  a QUEUE_DEPTH-entry queue; the result stage reads the queue into the rsp_
//  output register. A result is written into the queue at the accepting edge
//  of the byte that caused it and moves on into the output register once that
//  register is free. When the receiver stalls, the output register holds its
//  beat and the queue fills; req_ready drops only once the queue is full.
//  Reset (synchronous, active high) returns to the sync hunt and empties the
//  queue and output register. No clearing pass is needed.
`default_nettype none

module adts_frame_sync_parser #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_stream_byte,
   input  wire logic        req_end_of_stream,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_status,
   output logic             rsp_is_mpeg2,
   output logic [1:0]       rsp_profile,
   output logic [3:0]       rsp_rate_index,
   output logic [16:0]      rsp_sample_rate,
   output logic [2:0]       rsp_channel_config,
   output logic [12:0]      rsp_payload_length,
   output logic             rsp_crc_present
);
   import afsp_pkg::*;

   logic           evt_push;
   afsp_event_type evt_data;
   logic           q_full;
   logic           q_pop;
   logic           q_not_empty;
   afsp_event_type q_data;

   afsp_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_stream_byte   (req_stream_byte),
      .req_end_of_stream (req_end_of_stream),
      .q_full            (q_full),
      .evt_push          (evt_push),
      .evt_data          (evt_data)
   );

   afsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (evt_push),
      .push_data (evt_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_data)
   );

   afsp_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_not_empty        (q_not_empty),
      .q_data             (q_data),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_is_mpeg2       (rsp_is_mpeg2),
      .rsp_profile        (rsp_profile),
      .rsp_rate_index     (rsp_rate_index),
      .rsp_sample_rate    (rsp_sample_rate),
      .rsp_channel_config (rsp_channel_config),
      .rsp_payload_length (rsp_payload_length),
      .rsp_crc_present    (rsp_crc_present)
   );

endmodule

`default_nettype wire

>>> tb/sv/tb_adts_frame_sync_parser.sv
// Self-checking testbench for the ADTS frame sync parser with a byte-level parser predictor.
`timescale 1ns / 1ps

module tb_adts_frame_sync_parser;
   import afsp_pkg::*;

   typedef logic [0:6][7:0] hdr_bytes_type;

   typedef struct packed {
      logic        status;
      logic        is_mpeg2;
      logic [1:0]  profile;
      logic [3:0]  rate_index;
      logic [16:0] sample_rate;
      logic [2:0]  channel_config;
      logic [12:0] payload_length;
      logic        crc_present;
   } frame_report_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } stream_beat_type;

   localparam logic [2:0] SEEK_FF    = 3'd0;
   localparam logic [2:0] SEEK_SYNC  = 3'd1;
   localparam logic [2:0] TAKE_HDR   = 3'd2;
   localparam logic [2:0] SKIP_BODY  = 3'd3;
   localparam logic [2:0] CHECK_NEXT = 3'd4;
   localparam logic [2:0] REPORT_BAD = 3'd5;

   localparam int BEATS_PER_PHASE = 200;
   localparam int DRAIN_CYCLES    = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_stream_byte = 8'h00;
   logic        req_end_of_stream = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_status;
   logic        rsp_is_mpeg2;
   logic [1:0]  rsp_profile;
   logic [3:0]  rsp_rate_index;
   logic [16:0] rsp_sample_rate;
   logic [2:0]  rsp_channel_config;
   logic [12:0] rsp_payload_length;
   logic        rsp_crc_present;

   stream_beat_type  pending_beats[$];
   frame_report_type expected_reports[$];
   stream_beat_type  next_beat;
   frame_report_type seen_report;
   frame_report_type want_report;
   int               beats_queued = 0;
   int               errors = 0;
   int               send_idle_pct = 0;
   int               recv_stall_pct = 0;

   logic [2:0]       ps;
   hdr_bytes_type    cur_hdr;
   hdr_bytes_type    nxt_hdr;
   logic [12:0]      pos;
   logic             nxt_match;

   adts_frame_sync_parser uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_stream_byte    (req_stream_byte),
      .req_end_of_stream  (req_end_of_stream),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_is_mpeg2       (rsp_is_mpeg2),
      .rsp_profile        (rsp_profile),
      .rsp_rate_index     (rsp_rate_index),
      .rsp_sample_rate    (rsp_sample_rate),
      .rsp_channel_config (rsp_channel_config),
      .rsp_payload_length (rsp_payload_length),
      .rsp_crc_present    (rsp_crc_present)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [12:0] frame_len(input hdr_bytes_type h);
      return {h[3][1:0], h[4], h[5][7:5]};
   endfunction

   function automatic logic hdr_ok(input hdr_bytes_type h);
      return (h[2][5:2] < 4'd13) && !(h[1][3] && h[2][7:6] == 2'd3);
   endfunction

   function automatic logic [16:0] sample_rate_hz(input logic [3:0] idx);
      case (idx)
         4'd0:    return 17'd96000;
         4'd1:    return 17'd88200;
         4'd2:    return 17'd64000;
         4'd3:    return 17'd48000;
         4'd4:    return 17'd44100;
         4'd5:    return 17'd32000;
         4'd6:    return 17'd24000;
         4'd7:    return 17'd22050;
         4'd8:    return 17'd16000;
         4'd9:    return 17'd12000;
         4'd10:   return 17'd11025;
         4'd11:   return 17'd8000;
         4'd12:   return 17'd7350;
         default: return 17'd0;
      endcase
   endfunction

   function automatic frame_report_type frame_fields(input hdr_bytes_type h);
      frame_report_type r;
      r.status         = STATUS_OK;
      r.is_mpeg2       = h[1][3];
      r.profile        = h[2][7:6];
      r.rate_index     = h[2][5:2];
      r.sample_rate    = sample_rate_hz(h[2][5:2]);
      r.channel_config = {h[2][0], h[3][7:6]};
      r.payload_length = frame_len(h) - 13'd7;
      r.crc_present    = ~h[1][0];
      return r;
   endfunction

   function automatic void begin_frame();
      if (frame_len(cur_hdr) > 13'd7) begin
         ps  = SKIP_BODY;
         pos = 13'd7;
      end else begin
         ps        = CHECK_NEXT;
         pos       = 13'd0;
         nxt_match = 1'b1;
      end
   endfunction

   function automatic void advance_parser(input logic [7:0] b, input logic eos);
      frame_report_type bad;
      logic             emitted;
      bad        = '0;
      bad.status = STATUS_CORRUPT;
      emitted    = 1'b0;
      if (ps == REPORT_BAD) begin
         expected_reports.push_back(bad);
         emitted = 1'b1;
         ps      = SEEK_FF;
      end
      case (ps)
         SEEK_SYNC: begin
            if ((b & 8'hF6) == 8'hF0) begin
               cur_hdr[1] = b;
               pos        = 13'd2;
               ps         = TAKE_HDR;
            end else if (b != 8'hFF) begin
               ps = SEEK_FF;
            end
         end
         TAKE_HDR: begin
            cur_hdr[pos] = b;
            pos = pos + 13'd1;
            if (pos >= 13'd7) begin
               if (!hdr_ok(cur_hdr) || frame_len(cur_hdr) < 13'd7) begin
                  expected_reports.push_back(bad);
                  emitted = 1'b1;
                  ps      = SEEK_FF;
                  pos     = 13'd0;
               end else begin
                  begin_frame();
               end
            end
         end
         SKIP_BODY: begin
            pos = pos + 13'd1;
            if (pos >= frame_len(cur_hdr)) begin
               ps        = CHECK_NEXT;
               pos       = 13'd0;
               nxt_match = 1'b1;
            end
         end
         CHECK_NEXT: begin
            nxt_hdr[pos] = b;
            if (pos < 13'd3) begin
               if (b != cur_hdr[pos]) nxt_match = 1'b0;
            end else if (pos == 13'd3) begin
               if (b[7:4] != cur_hdr[3][7:4]) nxt_match = 1'b0;
            end
            pos = pos + 13'd1;
            if (pos >= 13'd7) begin
               if (nxt_match && hdr_ok(nxt_hdr)) begin
                  expected_reports.push_back(frame_fields(cur_hdr));
                  emitted = 1'b1;
                  cur_hdr = nxt_hdr;
                  if (frame_len(cur_hdr) < 13'd7) begin
                     ps  = REPORT_BAD;
                     pos = 13'd0;
                  end else begin
                     begin_frame();
                  end
               end else begin
                  expected_reports.push_back(bad);
                  emitted = 1'b1;
                  ps      = SEEK_FF;
                  pos     = 13'd0;
               end
            end
         end
         default: begin
            if (b == 8'hFF) begin
               cur_hdr[0] = b;
               ps         = SEEK_SYNC;
            end else begin
               ps = SEEK_FF;
            end
         end
      endcase
      if (eos) begin
         if (!emitted && ps == CHECK_NEXT) expected_reports.push_back(frame_fields(cur_hdr));
         ps        = SEEK_FF;
         pos       = 13'd0;
         nxt_match = 1'b1;
      end
   endfunction

   function automatic void push_beat(input logic [7:0] d, input logic l);
      stream_beat_type sb;
      sb.data = d;
      sb.last = l;
      pending_beats.push_back(sb);
      beats_queued++;
   endfunction

   function automatic void queue_frame(input logic [7:0] b1, input logic [7:0] b2,
                                       input logic [3:0] b3hi, input logic [12:0] len,
                                       input int eos_at);
      int          n;
      logic [31:0] r;
      logic [7:0]  d;
      n = (len < 13'd7) ? 7 : int'(len);
      for (int i = 0; i < n; i++) begin
         r = $urandom;
         case (i)
            0:       d = 8'hFF;
            1:       d = b1;
            2:       d = b2;
            3:       d = {b3hi, r[3:2], len[12:11]};
            4:       d = len[10:3];
            5:       d = {len[2:0], r[4:0]};
            default: d = r[7:0];
         endcase
         push_beat(d, i == eos_at);
      end
   endfunction

   function automatic void queue_stream();
      logic [31:0] r;
      logic [7:0]  b1;
      logic [7:0]  b2;
      logic [3:0]  b3hi;
      logic [12:0] len;
      int          nframes;
      int          eos_mode;
      int          eos_frame;
      int          n;
      int          eos_at;
      int          flip;
      for (int i = $urandom_range(0, 3); i > 0; i--) begin
         r = $urandom;
         push_beat((r[9:8] == 2'd0) ? 8'hFF : r[7:0], r[15:12] == 4'd0);
      end
      r    = $urandom;
      b1   = {4'hF, r[3], 2'b00, r[0]};
      if ($urandom_range(0, 15) == 0) b1[2:1] = 2'($urandom_range(1, 3));
      b2   = r[15:8];
      if ($urandom_range(0, 9) != 0) b2[5:2] = 4'($urandom_range(0, 12));
      b3hi = r[19:16];
      nframes   = $urandom_range(1, 5);
      eos_mode  = $urandom_range(0, 7);
      eos_frame = $urandom_range(0, nframes - 1);
      for (int f = 0; f < nframes; f++) begin
         case ($urandom_range(0, 29))
            0, 1:    len = 13'($urandom_range(0, 6));
            2:       len = 13'($urandom_range(25, 300));
            default: len = 13'($urandom_range(7, 24));
         endcase
         if (f > 0 && $urandom_range(0, 11) == 0) begin
            flip = $urandom_range(0, 19);
            if (flip < 8) b1[flip] = ~b1[flip];
            else if (flip < 16) b2[flip - 8] = ~b2[flip - 8];
            else b3hi[flip - 16] = ~b3hi[flip - 16];
         end
         n = (len < 13'd7) ? 7 : int'(len);
         eos_at = -1;
         if (eos_mode <= 5 && f == nframes - 1) eos_at = n - 1;
         if (eos_mode == 6 && f == eos_frame) eos_at = $urandom_range(0, n - 1);
         queue_frame(b1, b2, b3hi, len, eos_at);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) advance_parser(req_stream_byte, req_end_of_stream);
         if (!req_valid || req_ready) begin
            if (pending_beats.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               next_beat = pending_beats.pop_front();
               req_valid         <= 1'b1;
               req_stream_byte   <= next_beat.data;
               req_end_of_stream <= next_beat.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen_report.status         = rsp_status;
            seen_report.is_mpeg2       = rsp_is_mpeg2;
            seen_report.profile        = rsp_profile;
            seen_report.rate_index     = rsp_rate_index;
            seen_report.sample_rate    = rsp_sample_rate;
            seen_report.channel_config = rsp_channel_config;
            seen_report.payload_length = rsp_payload_length;
            seen_report.crc_present    = rsp_crc_present;
            if (expected_reports.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected beat: got %p", seen_report);
            end else begin
               want_report = expected_reports.pop_front();
               if (seen_report !== want_report) begin
                  errors++;
                  if (errors <= 10)
                     $display("beat mismatch: expected %p got %p", want_report, seen_report);
               end
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   initial begin
      int target;
      ps        = SEEK_FF;
      cur_hdr   = '0;
      nxt_hdr   = '0;
      pos       = 13'd0;
      nxt_match = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      push_beat(8'h00, 1'b0);
      push_beat(8'hFF, 1'b0);
      queue_frame(8'hF1, 8'h50, 4'h8, 13'd7, -1);
      queue_frame(8'hF1, 8'h50, 4'h8, 13'd9, 8);
      queue_frame(8'hF8, 8'h34, 4'h0, 13'd7, 6);
      queue_frame(8'hF8, 8'hF3, 4'hC, 13'd7, 6);
      queue_frame(8'hF0, 8'hF3, 4'hF, 13'd7, -1);
      queue_frame(8'hF0, 8'hF3, 4'hF, 13'd7, 6);
      queue_frame(8'hF1, 8'h00, 4'h0, 13'd3, 6);
      queue_frame(8'hF1, 8'h50, 4'h8, 13'd7, -1);
      queue_frame(8'hF1, 8'h54, 4'h8, 13'd7, -1);
      queue_frame(8'hF1, 8'h50, 4'h8, 13'd7, -1);
      queue_frame(8'hF1, 8'h50, 4'h8, 13'd2, -1);
      push_beat(8'h00, 1'b1);
      queue_frame(8'hF1, 8'h50, 4'h8, 13'd7, -1);
      queue_frame(8'hF1, 8'h50, 4'h8, 13'd2, 6);
      queue_frame(8'hF9, 8'h50, 4'h8, 13'd20, 10);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 50; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 50; end
            default: begin send_idle_pct = 22; recv_stall_pct = 22; end
         endcase
         target = beats_queued + BEATS_PER_PHASE;
         while (beats_queued < target) queue_stream();
         if (ph == 3) begin
            queue_frame(8'hF1, 8'h4F, 4'hF, 13'd40, -1);
            queue_frame(8'hF1, 8'h4F, 4'hF, 13'd7, 6);
         end
         while (pending_beats.size() > 0) @(negedge clock);
      end

      while (req_valid || expected_reports.size() > 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (errors == 0 && expected_reports.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
